/* hw/rtl/kvt_pkg.sv */
`default_nettype none

package kvt_pkg;

	// operation codes carried on mode
	localparam logic [2:0] MODE_CLEAR  = 3'd0;
	localparam logic [2:0] MODE_INSERT = 3'd1;
	localparam logic [2:0] MODE_ERASE  = 3'd2;
	localparam logic [2:0] MODE_LOOKUP = 3'd3;
	localparam logic [2:0] MODE_COUNT  = 3'd4;

	// result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;

	// width of the count fields in a result
	localparam int CNT_OUT_W = 6;

	// scan unit control, driven by the sequencer
	typedef struct packed {
		logic init;      // clear match state at the start of a transaction
		logic sample;    // read data on the store outputs belongs to this scan
		logic by_value;  // count values instead of searching keys
	} scan_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/keyed_value_table_top.sv */
// Channel   Handshake          Payload
// -------   ----------------   ------------------------------------------
// command   start / busy       mode, key, value
// result    done (1-cycle)     status, read_value, match_count, fill_count
//
// A transaction is taken at an edge with start high and busy low. Clear, insert,
// unused modes and any mode on an empty table give done in the next cycle; the next
// command may follow at once. Erase, lookup and count otherwise scan one slot per
// cycle; done follows once the last read has been sampled. Erase of a present key adds a
// read of the last slot and a write-back before done. Reset empties the table at once;
// memory contents stay undefined. The result side cannot stall.
`default_nettype none

module keyed_value_table_top #(
	parameter int TABLE_DEPTH = 32,
	parameter int KEY_BITS    = 16,
	parameter int VALUE_BITS  = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [2:0]                            mode,
	input  wire logic [KEY_BITS-1:0]                   key,
	input  wire logic [VALUE_BITS-1:0]                 value,
	output logic                                       done,
	output logic      [1:0]                            status,
	output logic      [VALUE_BITS-1:0]                 read_value,
	output logic      [kvt_pkg::CNT_OUT_W-1:0]         match_count,
	output logic      [kvt_pkg::CNT_OUT_W-1:0]         fill_count
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_ERD  = 4'b0100,
		ST_EWR  = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           iss_q;
	logic                    smp_s1;
	logic [AW-1:0]           idx_s1;
	logic [2:0]              mode_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [VALUE_BITS-1:0]   value_q;
	logic                    done_q;
	logic [1:0]              status_q;
	logic [VALUE_BITS-1:0]   rv_q;
	logic [CW-1:0]           mc_q;
	logic [CW-1:0]           fill_q;

	logic                    accept;
	logic                    full;
	logic                    issue;
	logic                    scan_end;
	logic [CW-1:0]           last_c;

	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [KEY_BITS-1:0]     wr_key;
	logic [VALUE_BITS-1:0]   wr_value;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic [KEY_BITS-1:0]     rd_key;
	logic [VALUE_BITS-1:0]   rd_value;

	kvt_pkg::scan_ctl_t      ctl;
	logic                    found;
	logic [AW-1:0]           found_idx;
	logic [VALUE_BITS-1:0]   found_value;
	logic [CW-1:0]           hit_count;

	logic                    fin;
	logic [1:0]              res_status;
	logic [VALUE_BITS-1:0]   res_rv;
	logic [CW-1:0]           res_mc;
	logic [CW-1:0]           res_fill;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign full     = (cnt_q == CW'(TABLE_DEPTH));
	assign issue    = (state_q == ST_SCAN) && (iss_q != cnt_q);
	// last read has been sampled by the match unit
	assign scan_end = (state_q == ST_SCAN) && (iss_q == cnt_q) && !smp_s1;
	assign last_c   = cnt_q - CW'(1);

	kvt_store #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS),
		.VALUE_BITS  (VALUE_BITS),
		.AW          (AW)
	) u_store (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_key   (wr_key),
		.wr_value (wr_value),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_key   (rd_key),
		.rd_value (rd_value)
	);

	kvt_match #(
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS),
		.AW         (AW),
		.CW         (CW)
	) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.idx         (idx_s1),
		.rd_key      (rd_key),
		.rd_value    (rd_value),
		.tgt_key     (key_q),
		.tgt_value   (value_q),
		.found       (found),
		.found_idx   (found_idx),
		.found_value (found_value),
		.hit_count   (hit_count)
	);

	// memory access; one op per transaction is in flight, so a write never
	// overlaps a read of the same slot
	always_comb begin
		wr_en        = 1'b0;
		wr_addr      = cnt_q[AW-1:0];
		wr_key       = key;
		wr_value     = value;
		rd_en        = 1'b0;
		rd_addr      = iss_q[AW-1:0];
		ctl.init     = 1'b0;
		ctl.sample   = 1'b0;
		ctl.by_value = (mode_q == kvt_pkg::MODE_COUNT);
		unique case (state_q)
			ST_IDLE: begin
				ctl.init = accept;
				if (accept && (mode == kvt_pkg::MODE_INSERT) && !full)
					wr_en = 1'b1;
			end
			ST_SCAN: begin
				rd_en      = issue;
				ctl.sample = smp_s1;
			end
			ST_ERD: begin
				rd_en   = 1'b1;
				rd_addr = last_c[AW-1:0];
			end
			ST_EWR: begin
				// move the last pair into the erased slot
				wr_en    = 1'b1;
				wr_addr  = found_idx;
				wr_key   = rd_key;
				wr_value = rd_value;
			end
			default: begin
			end
		endcase
	end

	// result of the transaction that finishes in this cycle
	always_comb begin
		fin        = 1'b0;
		res_status = kvt_pkg::STAT_OK;
		res_rv     = '0;
		res_mc     = '0;
		res_fill   = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (mode)
						kvt_pkg::MODE_CLEAR: begin
							fin      = 1'b1;
							res_fill = '0;
						end
						kvt_pkg::MODE_INSERT: begin
							fin = 1'b1;
							if (full)
								res_status = kvt_pkg::STAT_FULL;
							else
								res_fill = cnt_q + CW'(1);
						end
						kvt_pkg::MODE_ERASE, kvt_pkg::MODE_LOOKUP: begin
							if (cnt_q == '0) begin
								fin        = 1'b1;
								res_status = kvt_pkg::STAT_NOT_FOUND;
							end
						end
						kvt_pkg::MODE_COUNT: begin
							fin = (cnt_q == '0);
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					priority if (mode_q == kvt_pkg::MODE_COUNT) begin
						fin    = 1'b1;
						res_mc = hit_count;
					end else if (!found) begin
						fin        = 1'b1;
						res_status = kvt_pkg::STAT_NOT_FOUND;
					end else if (mode_q == kvt_pkg::MODE_LOOKUP) begin
						fin    = 1'b1;
						res_rv = found_value;
					end
				end
			end
			ST_EWR: begin
				fin      = 1'b1;
				res_fill = last_c;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			iss_q   <= '0;
			smp_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin;
			smp_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						iss_q <= '0;
						if (fin)
							cnt_q <= res_fill;
						else
							state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue)
						iss_q <= iss_q + CW'(1);
					if (scan_end)
						state_q <= fin ? ST_IDLE : ST_ERD;
				end
				ST_ERD: begin
					state_q <= ST_EWR;
				end
				ST_EWR: begin
					cnt_q   <= last_c;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[AW-1:0];
		if (accept) begin
			mode_q  <= mode;
			key_q   <= key;
			value_q <= value;
		end
		if (fin) begin
			status_q <= res_status;
			rv_q     <= res_rv;
			mc_q     <= res_mc;
			fill_q   <= res_fill;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign read_value  = rv_q;
	assign match_count = kvt_pkg::CNT_OUT_W'(mc_q);
	assign fill_count  = kvt_pkg::CNT_OUT_W'(fill_q);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !wr_en)
		else $error("memory write during scan");

	a_insert_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (mode == kvt_pkg::MODE_INSERT) && !full)
		|=> (done && (cnt_q == $past(cnt_q) + CW'(1))))
		else $error("insert did not complete in one cycle");

	a_erase_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EWR) |=> (done && (cnt_q == $past(last_c))))
		else $error("erase did not shrink the table");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result without a transaction");

endmodule

`default_nettype wire

/* hw/rtl/kvt_store.sv */
`default_nettype none

module kvt_store #(
	parameter int TABLE_DEPTH = 32,
	parameter int KEY_BITS    = 16,
	parameter int VALUE_BITS  = 32,
	parameter int AW          = 5
) (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [AW-1:0]         wr_addr,
	input  wire logic [KEY_BITS-1:0]   wr_key,
	input  wire logic [VALUE_BITS-1:0] wr_value,
	input  wire logic                  rd_en,
	input  wire logic [AW-1:0]         rd_addr,
	output logic      [KEY_BITS-1:0]   rd_key,
	output logic      [VALUE_BITS-1:0] rd_value
);

	logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
	logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key   <= key_mem[rd_addr];
			rd_value <= val_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/kvt_match.sv */
`default_nettype none

module kvt_match #(
	parameter int KEY_BITS   = 16,
	parameter int VALUE_BITS = 32,
	parameter int AW         = 5,
	parameter int CW         = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire kvt_pkg::scan_ctl_t    ctl,
	input  wire logic [AW-1:0]         idx,
	input  wire logic [KEY_BITS-1:0]   rd_key,
	input  wire logic [VALUE_BITS-1:0] rd_value,
	input  wire logic [KEY_BITS-1:0]   tgt_key,
	input  wire logic [VALUE_BITS-1:0] tgt_value,
	output logic                       found,
	output logic      [AW-1:0]         found_idx,
	output logic      [VALUE_BITS-1:0] found_value,
	output logic      [CW-1:0]         hit_count
);

	logic                  found_q;
	logic [AW-1:0]         idx_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CW-1:0]         mc_q;
	logic                  key_hit;
	logic                  val_hit;
	logic                  first_hit;

	assign key_hit   = (rd_key == tgt_key);
	assign val_hit   = (rd_value == tgt_value);
	// only the lowest matching slot counts
	assign first_hit = ctl.sample && !ctl.by_value && key_hit && !found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			mc_q    <= '0;
		end else if (ctl.init) begin
			found_q <= 1'b0;
			mc_q    <= '0;
		end else begin
			if (first_hit)
				found_q <= 1'b1;
			if (ctl.sample && ctl.by_value && val_hit)
				mc_q <= mc_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (first_hit) begin
			idx_q <= idx;
			val_q <= rd_value;
		end
	end

	assign found       = found_q;
	assign found_idx   = idx_q;
	assign found_value = val_q;
	assign hit_count   = mc_q;

endmodule

`default_nettype wire
